@@ design/afsd_pkg.sv @@
// Shared constants, types and helpers for the allele frequency selection/drift block.
// Used by every module of the block; no dependencies.
`default_nettype none
package afsd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FW        = FRAC_BITS + 1;
	localparam int CFG_W     = 17;
	localparam int CNT_W     = 24;
	localparam int PW        = (FW > CFG_W) ? FW : CFG_W;
	localparam int MW        = (FW + 2 > 19) ? FW + 2 : 19;
	localparam int PRW       = 2 * MW;
	localparam int AW        = 2 * FRAC_BITS + 3;
	localparam int DCW       = $clog2(FRAC_BITS + 1);
	localparam int RS_W      = 16;
	localparam int OUT_FW    = 17;
	localparam int OUT_DW    = 48;

	localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam int INIT_RST       = 32768;
	localparam logic [FW-1:0] FREQ_RST = (INIT_RST > 2**FRAC_BITS) ? ONE : FW'(INIT_RST);

	typedef enum logic [2:0] {
		REG_INIT      = 3'd0,
		REG_PEN_DOM   = 3'd1,
		REG_PEN_HET   = 3'd2,
		REG_PEN_REC   = 3'd3,
		REG_AMP       = 3'd4,
		REG_GEN_COUNT = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [FW-1:0]    init_p;
		logic [FW-1:0]    fit_dom;
		logic [FW-1:0]    fit_het;
		logic [FW-1:0]    fit_rec;
		logic [CFG_W-1:0] amp;
		logic [CNT_W-1:0] last_idx;
	} cfg_t;

	function automatic logic [FW-1:0] clamp_one(input logic [PW-1:0] v);
		logic [PW-1:0] one_w;
		one_w = PW'(ONE);
		return (v > one_w) ? ONE : v[FW-1:0];
	endfunction

endpackage
`default_nettype wire

@@ design/afsd_cfg.sv @@
// Configuration register file: takes register writes and derives fitness values.
// Depends on afsd_pkg.
`default_nettype none
module afsd_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [afsd_pkg::CNT_W-1:0] cfg_data,
	output afsd_pkg::cfg_t                 cfg
);
	import afsd_pkg::*;

	logic [CFG_W-1:0] init_q, pen_dom_q, pen_het_q, pen_rec_q, amp_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= CFG_W'(INIT_RST);
			pen_dom_q <= '0;
			pen_het_q <= '0;
			pen_rec_q <= '0;
			amp_q     <= '0;
			count_q   <= CNT_W'(1);
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_INIT:      init_q    <= cfg_data[CFG_W-1:0];
				REG_PEN_DOM:   pen_dom_q <= cfg_data[CFG_W-1:0];
				REG_PEN_HET:   pen_het_q <= cfg_data[CFG_W-1:0];
				REG_PEN_REC:   pen_rec_q <= cfg_data[CFG_W-1:0];
				REG_AMP:       amp_q     <= cfg_data[CFG_W-1:0];
				REG_GEN_COUNT: count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.init_p   = clamp_one(PW'(init_q));
		cfg.fit_dom  = ONE - clamp_one(PW'(pen_dom_q));
		cfg.fit_het  = ONE - clamp_one(PW'(pen_het_q));
		cfg.fit_rec  = ONE - clamp_one(PW'(pen_rec_q));
		cfg.amp      = amp_q;
		cfg.last_idx = count_q - CNT_W'(1);
	end

endmodule
`default_nettype wire

@@ design/afsd_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on afsd_pkg.
`default_nettype none
module afsd_mul (
	input  wire logic                           clk,
	input  wire logic signed [afsd_pkg::MW-1:0]  a,
	input  wire logic signed [afsd_pkg::MW-1:0]  b,
	output logic signed [afsd_pkg::PRW-1:0]      prod_q
);
	import afsd_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

@@ design/afsd_div.sv @@
// Restoring divider, one quotient bit per cycle, FRAC_BITS fraction bits.
// Depends on afsd_pkg.
`default_nettype none
module afsd_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [afsd_pkg::AW-1:0] num,
	input  wire logic [afsd_pkg::AW-1:0] den,
	output logic                         done,
	output logic [afsd_pkg::FW-1:0]      quot
);
	import afsd_pkg::*;

	logic            busy_q, done_q;
	logic [DCW-1:0]  cnt_q;
	logic [AW-1:0]   rem_q, den_q;
	logic [FW-1:0]   quot_q;
	logic            first_bit;
	logic [AW:0]     rem2;
	logic            sub_ok;

	always_comb begin
		first_bit = (num >= den);
		rem2      = {rem_q, 1'b0};
		sub_ok    = (rem2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCW'(1);
				if (cnt_q == DCW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= first_bit ? (num - den) : num;
			quot_q <= FW'(first_bit);
		end else if (busy_q) begin
			rem_q  <= sub_ok ? AW'(rem2 - {1'b0, den_q}) : rem2[AW-1:0];
			quot_q <= {quot_q[FW-2:0], sub_ok};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

@@ design/allele_frequency_selection_drift.sv @@
// Allele frequency under Hardy-Weinberg selection with genetic drift: top level.
// Uses afsd_pkg, afsd_cfg, afsd_mul and afsd_div.
// Each accepted item is one generation and passes through these steps before the next
// can be taken (a new frequency fixed at 0 or 1 gets no drift, and zero total fitness
// skips division and drift): seven steps on the one shared multiplier for the
// genotype terms, the bit-serial divider that forms p' = num / W, the drift product
// and its sum, loading the result register once it is free, and the idle state with
// s_tready high in which the next item is taken.
// The result register frees the input side while a result waits to be taken.
`default_nettype none
module allele_frequency_selection_drift (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [afsd_pkg::RS_W-1:0]     s_tdata,   // [15:0] random_sample
	input  wire logic                          s_tuser,   // [0] restart
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [afsd_pkg::OUT_DW-1:0]        m_tdata,   // [16:0] frequency, [40:17] generation_index
	output logic                               m_tlast,
	output logic                               m_tuser,   // [0] zero_fitness
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [afsd_pkg::CNT_W-1:0]    cfg_data
);
	import afsd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV, ST_DRIFT, ST_ADJ, ST_DONE
	} state_t;

	state_t              state_q;
	logic [2:0]          step_q;
	logic [FW-1:0]       freq_q, p_q, pp_q, pq_q, qq_q, newp_q;
	logic [CNT_W-1:0]    gen_q, idx_q;
	logic                last_q, zero_q;
	logic [RS_W-1:0]     r_q;
	logic [AW-1:0]       acc_q, w_q;
	logic                out_valid_q, out_last_q, out_zero_q;
	logic [OUT_FW-1:0]   out_freq_q;
	logic [CNT_W-1:0]    out_idx_q;

	cfg_t                     cfg;
	logic signed [MW-1:0]     mul_a, mul_b;
	logic signed [PRW-1:0]    prod_q;
	logic                     div_start, div_done;
	logic [FW-1:0]            div_quot;
	logic [FW-1:0]            q_val, quot_c, adj_p;
	logic [AW-1:0]            prod_lo, w_next;
	logic signed [PRW-1:0]    adj_sum;
	logic signed [17:0]       drift_a;
	logic                     accept, out_free;
	logic [FW-1:0]            start_p;
	logic [CNT_W-1:0]         start_gen;

	afsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	afsd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	afsd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (w_next),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		q_val     = ONE - p_q;
		drift_a   = $signed({1'b0, r_q, 1'b0}) - 18'sd65536;
		prod_lo   = prod_q[AW-1:0];
		w_next    = w_q + prod_lo;
		div_start = (state_q == ST_MUL) && (step_q == 3'd6) && (w_next != '0);
		quot_c    = clamp_one(PW'(div_quot));
		adj_sum   = $signed({{(PRW-FW){1'b0}}, newp_q}) + (prod_q >>> 16);
		if (adj_sum <= 0) begin
			adj_p = '0;
		end else if (adj_sum > $signed({{(PRW-FW){1'b0}}, ONE})) begin
			adj_p = ONE;
		end else begin
			adj_p = adj_sum[FW-1:0];
		end
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_MUL) begin
			unique case (step_q)
				3'd0: begin mul_a = $signed(MW'(p_q));  mul_b = $signed(MW'(p_q));        end
				3'd1: begin mul_a = $signed(MW'(p_q));  mul_b = $signed(MW'(q_val));      end
				3'd2: begin mul_a = $signed(MW'(q_val)); mul_b = $signed(MW'(q_val));     end
				3'd3: begin mul_a = $signed(MW'(pp_q)); mul_b = $signed(MW'(cfg.fit_dom)); end
				3'd4: begin mul_a = $signed(MW'(pq_q)); mul_b = $signed(MW'(cfg.fit_het)); end
				3'd5: begin mul_a = $signed(MW'(qq_q)); mul_b = $signed(MW'(cfg.fit_rec)); end
				default: ;
			endcase
		end else if (state_q == ST_DRIFT) begin
			mul_a = {{(MW-18){drift_a[17]}}, drift_a};
			mul_b = $signed(MW'(cfg.amp));
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign start_p   = s_tuser ? cfg.init_p : freq_q;
	assign start_gen = s_tuser ? '0 : gen_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			freq_q      <= FREQ_RST;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						freq_q  <= start_p;
						gen_q   <= start_gen + CNT_W'(1);
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						state_q <= (w_next == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (quot_c == '0 || quot_c == ONE) begin
							freq_q  <= quot_c;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DRIFT;
						end
					end
				end
				ST_DRIFT: state_q <= ST_ADJ;
				ST_ADJ: begin
					freq_q  <= adj_p;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= start_p;
			idx_q  <= start_gen;
			last_q <= (start_gen == cfg.last_idx);
			r_q    <= s_tdata;
			zero_q <= 1'b0;
		end
		if (state_q == ST_MUL) begin
			unique case (step_q)
				3'd1: pp_q <= prod_q[FRAC_BITS +: FW];
				3'd2: pq_q <= prod_q[FRAC_BITS +: FW];
				3'd3: qq_q <= prod_q[FRAC_BITS +: FW];
				3'd4: acc_q <= prod_lo;
				3'd5: begin
					acc_q <= acc_q + prod_lo;
					w_q   <= acc_q + {prod_lo[AW-2:0], 1'b0};
				end
				3'd6: zero_q <= (w_next == '0);
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_done) begin
			newp_q <= quot_c;
		end
		if (state_q == ST_DONE && out_free) begin
			out_freq_q <= OUT_FW'(p_q);
			out_idx_q  <= idx_q;
			out_last_q <= last_q;
			out_zero_q <= zero_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DW - OUT_FW - CNT_W){1'b0}}, out_idx_q, out_freq_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_zero_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input ready while a generation is in progress");

	a_freq_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		freq_q <= ONE)
		else $error("allele frequency above one");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL) && (step_q == 3'd0))
		else $error("accepted item did not start the multiply sequence");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> m_tvalid && (state_q == ST_IDLE))
		else $error("finished generation did not produce a result");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for allele_frequency_selection_drift: directed and random generations with
// configuration phases, random idling on both streams and a self-checking scoreboard.
// Depends on afsd_pkg and the RTL top level only.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import afsd_pkg::*;

	localparam logic [2:0]  CFG_SPARE_LO = 3'd6;
	localparam logic [2:0]  CFG_SPARE_HI = 3'd7;
	localparam logic [63:0] FREQ_ONE     = 64'd1 << FRAC_BITS;
	localparam logic [63:0] DRIFT_BIAS   = 64'd1 << 40;
	localparam logic [63:0] DRIFT_OFFSET = 64'd1 << 24;
	localparam int          ITEMS_PER_PHASE = 106;
	localparam int          RANDOM_PHASES   = 8;

	typedef struct packed {
		logic [16:0] freq;
		logic [23:0] gen_idx;
		logic        last;
		logic        zero_fit;
	} gen_result_t;

	class gen_scoreboard;
		logic [16:0] init_reg, pen_dom_reg, pen_het_reg, pen_rec_reg, amp_reg;
		logic [23:0] count_reg;
		logic [63:0] freq_state;
		logic [23:0] gen_state;
		gen_result_t due_q[$];
		int          errors;

		function new();
			init_reg    = 17'd32768;
			pen_dom_reg = '0;
			pen_het_reg = '0;
			pen_rec_reg = '0;
			amp_reg     = '0;
			count_reg   = 24'd1;
			freq_state  = sat_unity(64'(init_reg));
			gen_state   = '0;
			errors      = 0;
		endfunction

		function logic [63:0] sat_unity(logic [63:0] v);
			return (v > FREQ_ONE) ? FREQ_ONE : v;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void note_config(logic [2:0] idx, logic [23:0] data);
			case (idx)
				REG_INIT:      init_reg    = data[16:0];
				REG_PEN_DOM:   pen_dom_reg = data[16:0];
				REG_PEN_HET:   pen_het_reg = data[16:0];
				REG_PEN_REC:   pen_rec_reg = data[16:0];
				REG_AMP:       amp_reg     = data[16:0];
				REG_GEN_COUNT: count_reg   = data;
				default: ;
			endcase
		endfunction

		function void note_input(logic [15:0] sample, logic restart);
			logic [63:0] p, q, pp, pq, qq, fd, fh, fr, num, w, quot, rem, biased, total;
			gen_result_t e;
			if (restart) begin
				freq_state = sat_unity(64'(init_reg));
				gen_state  = '0;
			end
			p          = sat_unity(freq_state);
			e.freq     = p[16:0];
			e.gen_idx  = gen_state;
			e.last     = (gen_state == count_reg - 24'd1);
			e.zero_fit = 1'b0;
			q   = FREQ_ONE - p;
			pp  = (p * p) >> FRAC_BITS;
			pq  = (p * q) >> FRAC_BITS;
			qq  = (q * q) >> FRAC_BITS;
			fd  = FREQ_ONE - sat_unity(64'(pen_dom_reg));
			fh  = FREQ_ONE - sat_unity(64'(pen_het_reg));
			fr  = FREQ_ONE - sat_unity(64'(pen_rec_reg));
			num = pp * fd + pq * fh;
			w   = num + pq * fh + qq * fr;
			if (w == 0) begin
				e.zero_fit = 1'b1;
			end else begin
				quot = (num >= w) ? 64'd1 : 64'd0;
				rem  = num - quot * w;
				for (int i = 0; i < FRAC_BITS; i++) begin
					rem  = rem << 1;
					quot = quot << 1;
					if (rem >= w) begin
						rem  = rem - w;
						quot = quot | 64'd1;
					end
				end
				p = sat_unity(quot);
				if (p > 0 && p < FREQ_ONE) begin
					biased = DRIFT_BIAS + 64'd2 * 64'(sample) * 64'(amp_reg)
						- 64'd65536 * 64'(amp_reg);
					total  = p + (biased >> 16);
					p = (total <= DRIFT_OFFSET) ? 64'd0 : sat_unity(total - DRIFT_OFFSET);
				end
				freq_state = p;
			end
			gen_state = gen_state + 24'd1;
			due_q.push_back(e);
		endfunction

		function void check_result(logic [16:0] freq, logic [23:0] gen_idx, logic last,
				logic zero_fit);
			gen_result_t e;
			if (due_q.size() == 0) begin
				$error("unexpected result: frequency %0d generation_index %0d", freq, gen_idx);
				errors++;
				return;
			end
			e = due_q.pop_front();
			if (freq !== e.freq) begin
				$error("frequency expected %0d actual %0d", e.freq, freq);
				errors++;
			end
			if (gen_idx !== e.gen_idx) begin
				$error("generation_index expected %0d actual %0d", e.gen_idx, gen_idx);
				errors++;
			end
			if (last !== e.last) begin
				$error("last expected %0d actual %0d", e.last, last);
				errors++;
			end
			if (zero_fit !== e.zero_fit) begin
				$error("zero_fitness expected %0d actual %0d", e.zero_fit, zero_fit);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	gen_scoreboard sb;
	int send_idle;
	int recv_stall;
	int hold_requests;

	allele_frequency_selection_drift DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else begin
				m_tready = ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[16:0], m_tdata[40:17], m_tlast, m_tuser);
	end

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic send_gen(input logic [15:0] sample, input logic restart);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			s_tdata  = 16'($urandom);
			s_tuser  = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = sample;
		s_tuser  = restart;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(sample, restart);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_config(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = 24'($urandom);
	endtask

	function automatic logic [23:0] with_noise(input logic [16:0] v);
		logic [6:0] hi;
		hi = 7'($urandom);
		return {hi, v};
	endfunction

	function automatic logic [16:0] pick_penalty();
		case ($urandom_range(9))
			0:       return 17'd65536;
			1:       return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 30000));
		endcase
	endfunction

	task automatic randomize_setup();
		logic [16:0] v;
		case ($urandom_range(7))
			0:       v = 17'd0;
			1:       v = 17'd65536;
			2:       v = 17'h1FFFF;
			default: v = 17'($urandom_range(0, 65536));
		endcase
		cfg_write(REG_INIT, with_noise(v));
		cfg_write(REG_PEN_DOM, with_noise(pick_penalty()));
		cfg_write(REG_PEN_HET, with_noise(pick_penalty()));
		cfg_write(REG_PEN_REC, with_noise(pick_penalty()));
		case ($urandom_range(11))
			0:       v = 17'd65536;
			1:       v = 17'($urandom_range(65537, 131071));
			default: v = 17'($urandom_range(0, 3000));
		endcase
		cfg_write(REG_AMP, with_noise(v));
		case ($urandom_range(9))
			0:       cfg_write(REG_GEN_COUNT, 24'd0);
			1:       cfg_write(REG_GEN_COUNT, 24'hFFFFFF);
			default: cfg_write(REG_GEN_COUNT, 24'($urandom_range(1, 24)));
		endcase
		if ($urandom_range(2) == 0)
			cfg_write($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 24'($urandom));
	endtask

	initial begin : stimulus
		logic [15:0] sample;
		sb            = new();
		send_idle     = 0;
		recv_stall    = 0;
		hold_requests = 0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_INIT;
		cfg_data      = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings
		send_gen(16'h0000, 1'b0);
		send_gen(16'hFFFF, 1'b0);

		// allele fixed at one and at zero
		cfg_write(REG_INIT, 24'd65536);
		cfg_write(REG_AMP, 24'd65536);
		cfg_write(REG_GEN_COUNT, 24'd3);
		send_gen(16'hAAAA, 1'b1);
		send_gen(16'h5555, 1'b0);
		send_gen(16'h0000, 1'b0);
		cfg_write(REG_INIT, 24'd0);
		send_gen(16'hFFFF, 1'b1);
		send_gen(16'h0000, 1'b0);

		// initial frequency and penalty above one
		cfg_write(REG_INIT, 24'h01FFFF);
		send_gen(16'h1234, 1'b1);
		cfg_write(REG_PEN_DOM, 24'hFFFFFF);
		send_gen(16'h0000, 1'b1);
		send_gen(16'hFFFF, 1'b0);

		// zero total fitness
		cfg_write(REG_INIT, 24'd32768);
		cfg_write(REG_PEN_HET, 24'd65536);
		cfg_write(REG_PEN_REC, 24'd65536);
		send_gen(16'h8000, 1'b1);
		send_gen(16'h7FFF, 1'b0);

		// full drift pushes to the bounds
		cfg_write(REG_PEN_DOM, 24'd0);
		cfg_write(REG_PEN_HET, 24'd0);
		cfg_write(REG_PEN_REC, 24'd0);
		send_gen(16'h0000, 1'b1);
		send_gen(16'h1111, 1'b0);
		send_gen(16'hFFFF, 1'b1);
		send_gen(16'h8000, 1'b1);
		cfg_write(REG_AMP, 24'h01FFFF);
		send_gen(16'h0000, 1'b1);
		send_gen(16'hFFFF, 1'b1);

		// count of zero, spare indexes, widest count
		cfg_write(REG_GEN_COUNT, 24'd0);
		cfg_write(CFG_SPARE_LO, 24'h000001);
		cfg_write(CFG_SPARE_HI, 24'hFFFFFF);
		cfg_write(REG_AMP, 24'd500);
		cfg_write(REG_PEN_DOM, 24'd20000);
		cfg_write(REG_PEN_REC, 24'd40000);
		send_gen(16'h4321, 1'b1);
		send_gen(16'hC0DE, 1'b0);
		cfg_write(REG_GEN_COUNT, 24'hFFFFFF);
		send_gen(16'h00FF, 1'b1);
		send_gen(16'hFF00, 1'b0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			randomize_setup();
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 59; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 59; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == 20 && (ph % 4) == 0)
					hold_requests++;
				case ($urandom_range(15))
					0:       sample = 16'h0000;
					1:       sample = 16'hFFFF;
					default: sample = 16'($urandom);
				endcase
				send_gen(sample, (n == 0) || ($urandom_range(11) == 0));
			end
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ allele_frequency_selection_drift.f @@
design/afsd_pkg.sv
design/afsd_cfg.sv
design/afsd_mul.sv
design/afsd_div.sv
design/allele_frequency_selection_drift.sv
sim/tb_top.sv
